>>> rtl/core/sfs_pkg.sv
// Shared constants, types and helpers for the serial frame synchronizer.
// Used by sfs_csr, sfs_ctrl, sfs_dpath and serial_frame_synchronizer.
package sfs_pkg;

   // Frame geometry
   localparam int FRAME_LEN = 14;
   localparam int PTR_W     = $clog2(FRAME_LEN);
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 4;
   localparam int CNT_W     = 8;

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_HEADER0   = 2'd1;
   localparam logic [1:0] REG_HEADER1   = 2'd2;
   localparam logic [1:0] REG_TRAILER   = 2'd3;

   localparam logic [BYTE_W-1:0] HEADER0_RST = 8'hFE;
   localparam logic [BYTE_W-1:0] HEADER1_RST = 8'h0A;
   localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h55;

   // Ring read address select
   localparam logic [1:0] RD_START  = 2'd0;
   localparam logic [1:0] RD_SECOND = 2'd1;
   localparam logic [1:0] RD_LAST   = 2'd2;
   localparam logic [1:0] RD_INDEX  = 2'd3;

   // Compare reference select
   localparam logic [1:0] CHK_HEADER0 = 2'd0;
   localparam logic [1:0] CHK_HEADER1 = 2'd1;
   localparam logic [1:0] CHK_TRAILER = 2'd2;

   typedef struct packed {
      logic              enable;
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] trailer_byte;
   } cfg_type;

   typedef struct packed {
      logic       wr_en;      // write received byte, advance write pointer
      logic       rd_en;      // launch a ring read
      logic [1:0] rd_sel;
      logic       match_clr;  // start a new frame check
      logic       chk_en;     // fold a compare into the match flag
      logic [1:0] chk_sel;
      logic       adv_start;  // slip the frame start by one byte
      logic       cnt_inc;    // count a validated frame
      logic       idx_clr;
      logic       out_load;   // load output register, advance byte index
   } cmd_type;

   typedef struct packed {
      logic frame_due;    // next write completes a candidate frame
      logic match_final;  // all three compares passed
      logic idx_last;     // byte index is at the final frame byte
      logic out_free;     // output register can take a byte this cycle
   } sts_type;

   // Pointer increment modulo the frame length
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(FRAME_LEN - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   // base + off modulo the frame length; both operands are below FRAME_LEN
   function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= (PTR_W+1)'(FRAME_LEN)) s = s - (PTR_W+1)'(FRAME_LEN);
      return s[PTR_W-1:0];
   endfunction

endpackage

>>> rtl/core/sfs_csr.sv
// Configuration registers of the frame synchronizer behind an APB-style port.
// Depends on sfs_pkg for register codes, reset values and cfg_type.
module sfs_csr
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_fire;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_idx)
            REG_ENABLE:  cfg_in.enable        = csr_pwdata[0];
            REG_HEADER0: cfg_in.header_first  = csr_pwdata[BYTE_W-1:0];
            REG_HEADER1: cfg_in.header_second = csr_pwdata[BYTE_W-1:0];
            REG_TRAILER: cfg_in.trailer_byte  = csr_pwdata[BYTE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.header_first  <= HEADER0_RST;
         cfg_ff.header_second <= HEADER1_RST;
         cfg_ff.trailer_byte  <= TRAILER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_ENABLE:  csr_prdata = CSR_DATA_W'(cfg_ff.enable);
         REG_HEADER0: csr_prdata = CSR_DATA_W'(cfg_ff.header_first);
         REG_HEADER1: csr_prdata = CSR_DATA_W'(cfg_ff.header_second);
         REG_TRAILER: csr_prdata = CSR_DATA_W'(cfg_ff.trailer_byte);
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/sfs_ctrl.sv
// Sequencer of the frame synchronizer: byte intake, frame check, emission.
// Depends on sfs_pkg for cmd_type, sts_type and select codes.
module sfs_ctrl
   import sfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    enable,
   input  sts_type sts,
   output logic    req_stall,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RD_HDR0   = 3'd1;
   localparam logic [2:0] ST_CK_HDR0   = 3'd2;
   localparam logic [2:0] ST_CK_HDR1   = 3'd3;
   localparam logic [2:0] ST_CK_TRAIL  = 3'd4;
   localparam logic [2:0] ST_EMIT_RD   = 3'd5;
   localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid & ~req_stall;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && enable) begin
               cmd.wr_en = 1'b1;
               if (sts.frame_due) state_in = ST_RD_HDR0;
            end
         end
         ST_RD_HDR0: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_START;
            cmd.match_clr = 1'b1;
            state_in      = ST_CK_HDR0;
         end
         ST_CK_HDR0: begin
            cmd.chk_en  = 1'b1;
            cmd.chk_sel = CHK_HEADER0;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_SECOND;
            state_in    = ST_CK_HDR1;
         end
         ST_CK_HDR1: begin
            cmd.chk_en  = 1'b1;
            cmd.chk_sel = CHK_HEADER1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LAST;
            state_in    = ST_CK_TRAIL;
         end
         ST_CK_TRAIL: begin
            cmd.chk_sel = CHK_TRAILER;
            if (sts.match_final) begin
               cmd.cnt_inc = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = ST_EMIT_RD;
            end else begin
               cmd.adv_start = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INDEX;
            state_in   = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.idx_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

>>> rtl/core/sfs_dpath.sv
// Datapath of the frame synchronizer: byte ring, pointers, compare, counter,
// and output register. Depends on sfs_pkg for types and ring helpers.
module sfs_dpath
   import sfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_frame_byte,
   output logic [POS_W-1:0]  rsp_byte_position,
   output logic              rsp_last_of_frame,
   output logic [CNT_W-1:0]  rsp_frames_seen
);

   logic [BYTE_W-1:0] ring_mem [FRAME_LEN];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  start_ptr_ff, start_ptr_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  frame_cnt_ff, frame_cnt_in;
   logic              match_ff, match_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic              out_last_ff;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic [PTR_W-1:0]  rd_off;
   logic [PTR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] chk_ref;
   logic              chk_eq;
   logic              idx_last;

   // ring read address: frame start plus selected offset
   always_comb begin
      case (cmd.rd_sel)
         RD_START:  rd_off = '0;
         RD_SECOND: rd_off = PTR_W'(1);
         RD_LAST:   rd_off = PTR_W'(FRAME_LEN - 1);
         RD_INDEX:  rd_off = idx_ff;
         default:   rd_off = '0;
      endcase
   end
   assign rd_addr = ring_addr(start_ptr_ff, rd_off);

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) ring_mem[wr_ptr_ff] <= req_rx_byte;
      if (cmd.rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   // compare of the read byte against the selected pattern
   always_comb begin
      case (cmd.chk_sel)
         CHK_HEADER0: chk_ref = cfg.header_first;
         CHK_HEADER1: chk_ref = cfg.header_second;
         CHK_TRAILER: chk_ref = cfg.trailer_byte;
         default:     chk_ref = cfg.trailer_byte;
      endcase
   end
   assign chk_eq   = (rd_data_ff == chk_ref);
   assign idx_last = (idx_ff == PTR_W'(FRAME_LEN - 1));

   // pointer, counter, match flag and output register updates
   always_comb begin
      wr_ptr_in    = cmd.wr_en ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      start_ptr_in = cmd.adv_start ? ptr_inc(start_ptr_ff) : start_ptr_ff;
      frame_cnt_in = cmd.cnt_inc ? frame_cnt_ff + CNT_W'(1) : frame_cnt_ff;
      match_in     = match_ff;
      if (cmd.match_clr) match_in = 1'b1;
      else if (cmd.chk_en) match_in = match_ff & chk_eq;
      idx_in = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.out_load) idx_in = idx_last ? '0 : idx_ff + PTR_W'(1);
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         start_ptr_ff <= '0;
         frame_cnt_ff <= '0;
         match_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         start_ptr_ff <= start_ptr_in;
         frame_cnt_ff <= frame_cnt_in;
         match_ff     <= match_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_byte_ff <= rd_data_ff;
         out_pos_ff  <= POS_W'(idx_ff);
         out_last_ff <= idx_last;
         out_cnt_ff  <= frame_cnt_ff;
      end
   end

   // status to the sequencer
   assign sts.frame_due   = (ptr_inc(wr_ptr_ff) == start_ptr_ff);
   assign sts.match_final = match_ff & chk_eq;
   assign sts.idx_last    = idx_last;
   assign sts.out_free    = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_byte    = out_byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_last_of_frame = out_last_ff;
   assign rsp_frames_seen   = out_cnt_ff;

endmodule

>>> rtl/core/serial_frame_synchronizer.sv
// Serial frame synchronizer top level: registers, sequencer and datapath.
// Depends on sfs_pkg, sfs_csr, sfs_ctrl and sfs_dpath.
//
// Usage: received bytes enter on the req_ channel (req_valid, req_stall,
// req_rx_byte). Once framing is enabled through the csr_ port, each byte goes
// into a 14-byte ring. When the ring holds a full candidate frame, the first
// two bytes are checked against the header registers and the last against the
// trailer register. A validated frame leaves on the rsp_ channel as 14
// transfers in order, each with its position, a last flag on the final byte
// and the wrapping frame count. A failed check slips the frame start by one
// byte and gives no output.
// Stalls: a byte that completes no candidate frame leaves req_stall low. A check
// raises req_stall for three reads of the single ring read port (ST_RD_HDR0,
// ST_CK_HDR0, ST_CK_HDR1) plus the trailer compare in ST_CK_TRAIL. A match then
// emits the frame through the same read port while the input stays stalled.
// Reset clears pointers, counter, sequencer and output valid; registers return
// to their defaults with framing off. While rsp_stall is high a valid output
// byte is held in the output register and emission waits; req_stall stays high until the
// last byte of the frame has been loaded into the output register.
module serial_frame_synchronizer
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_frame_byte,
   output logic [POS_W-1:0]      rsp_byte_position,
   output logic                  rsp_last_of_frame,
   output logic [CNT_W-1:0]      rsp_frames_seen,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   sfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .enable    (cfg.enable),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sfs_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cfg               (cfg),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frames_seen   (rsp_frames_seen)
   );

endmodule

>>> tb/sfs_frame_checker.sv
// Frame checker for the serial frame synchronizer: tracks register writes and
// byte transfers, predicts the emitted frame bytes and compares them on rsp_.
// Depends on sfs_pkg for widths, register indexes and register defaults.
module sfs_frame_checker
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [BYTE_W-1:0]     rsp_frame_byte,
   input  logic [POS_W-1:0]      rsp_byte_position,
   input  logic                  rsp_last_of_frame,
   input  logic [CNT_W-1:0]      rsp_frames_seen,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    frame_bytes_owed
);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
      logic [CNT_W-1:0]  count;
   } owed_byte_type;

   // Shadow of the block: ring, pointers, frame count and registers
   logic [BYTE_W-1:0] ring [FRAME_LEN];
   int                wr_slot;
   int                start_slot;
   logic [CNT_W-1:0]  frame_total;
   cfg_type           regs;
   owed_byte_type     owed_bytes[$];

   function automatic int ring_slot(input int base, input int off);
      return (base + off) % FRAME_LEN;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // One received byte: store it, and on a full window either slip or owe a frame
   task automatic absorb_rx_byte(input logic [BYTE_W-1:0] rx);
      owed_byte_type entry;
      bit            framed;
      if (!regs.enable) return;
      ring[wr_slot] = rx;
      wr_slot = ring_slot(wr_slot, 1);
      if (wr_slot != start_slot) return;
      framed = ring[ring_slot(start_slot, 0)] == regs.header_first
            && ring[ring_slot(start_slot, 1)] == regs.header_second
            && ring[ring_slot(start_slot, FRAME_LEN - 1)] == regs.trailer_byte;
      if (!framed) begin
         start_slot = ring_slot(start_slot, 1);
         return;
      end
      frame_total = frame_total + CNT_W'(1);
      for (int k = 0; k < FRAME_LEN; k++) begin
         entry.data  = ring[ring_slot(start_slot, k)];
         entry.pos   = POS_W'(k);
         entry.last  = (k == FRAME_LEN - 1);
         entry.count = frame_total;
         owed_bytes.push_back(entry);
      end
   endtask

   // Sample every channel at the rising edge
   always @(posedge clock) begin : watch
      owed_byte_type want;
      if (reset) begin
         foreach (ring[i]) ring[i] = '0;
         wr_slot = 0;
         start_slot = 0;
         frame_total = '0;
         regs.enable = 1'b0;
         regs.header_first = HEADER0_RST;
         regs.header_second = HEADER1_RST;
         regs.trailer_byte = TRAILER_RST;
         owed_bytes.delete();
      end else begin
         // register write completes on the access phase
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_ENABLE:  regs.enable = csr_pwdata[0];
               REG_HEADER0: regs.header_first = csr_pwdata[BYTE_W-1:0];
               REG_HEADER1: regs.header_second = csr_pwdata[BYTE_W-1:0];
               REG_TRAILER: regs.trailer_byte = csr_pwdata[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (owed_bytes.size() == 0) begin
               $error("frame byte %0h at position %0d with no frame owed",
                      rsp_frame_byte, rsp_byte_position);
               mismatch_count++;
            end else begin
               want = owed_bytes.pop_front();
               check_field("frame_byte", want.data, rsp_frame_byte);
               check_field("byte_position", want.pos, rsp_byte_position);
               check_field("last_of_frame", want.last, rsp_last_of_frame);
               check_field("frames_seen", want.count, rsp_frames_seen);
            end
         end
      end
      frame_bytes_owed <= owed_bytes.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top for the serial frame synchronizer: clock, reset, register
// setup, byte stimulus with idling and back-pressure, and the verdict.
// Depends on sfs_pkg, serial_frame_synchronizer and sfs_frame_checker.
module tb;
   import sfs_pkg::*;

   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_BYTES   = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_frame_byte;
   logic [POS_W-1:0]      rsp_byte_position;
   logic                  rsp_last_of_frame;
   logic [CNT_W-1:0]      rsp_frames_seen;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int frame_bytes_owed;
   int cycle_count = 0;
   int bytes_sent = 0;
   int send_idle_pct = 30;
   int stall_pct = 30;
   int hold_seq = 0;

   // Header and trailer currently programmed, used to build frames
   logic [BYTE_W-1:0] cur_h0 = HEADER0_RST;
   logic [BYTE_W-1:0] cur_h1 = HEADER1_RST;
   logic [BYTE_W-1:0] cur_tr = TRAILER_RST;

   serial_frame_synchronizer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frames_seen   (rsp_frames_seen),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   sfs_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frames_seen   (rsp_frames_seen),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatch_count    (mismatch_count),
      .frame_bytes_owed  (frame_bytes_owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off each time hold_seq moves
   initial begin : receiver
      int hold_done;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_done) begin
            hold_done = hold_seq;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // One byte transfer; valid stays up after acceptance until the next call
   // or drain() decides otherwise
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Full frame; body is alternating 00/FF or random, flip_at >= 0 breaks a byte
   task automatic send_frame(input bit extremes, input int flip_at);
      logic [BYTE_W-1:0] b;
      for (int k = 0; k < FRAME_LEN; k++) begin
         if (k == 0) b = cur_h0;
         else if (k == 1) b = cur_h1;
         else if (k == FRAME_LEN - 1) b = cur_tr;
         else if (extremes) b = k[0] ? 8'hFF : 8'h00;
         else b = BYTE_W'($urandom_range(255));
         if (k == flip_at) b = b ^ (BYTE_W'(1) << $urandom_range(BYTE_W - 1));
         send_byte(b);
      end
   endtask

   // Stop offering, wait for every owed frame byte, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_bytes_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: setup then access; upper data bits carry junk
   task automatic set_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      if (idx == REG_ENABLE) word[0] = value[0];
      else word[BYTE_W-1:0] = value;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic program_headers(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                                  input logic [BYTE_W-1:0] tr);
      set_reg(REG_HEADER0, h0);
      set_reg(REG_HEADER1, h1);
      set_reg(REG_TRAILER, tr);
      cur_h0 = h0;
      cur_h1 = h1;
      cur_tr = tr;
   endtask

   // Mostly framed traffic with random bodies, some broken frames and line noise
   task automatic stream_bytes(input int count);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < count) begin
         if ($urandom_range(99) < 75)
            send_frame(1'b0, ($urandom_range(99) < 20) ? $urandom_range(FRAME_LEN - 1) : -1);
         else
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // framing off after reset: bytes are dropped
      repeat (3) send_byte(BYTE_W'($urandom_range(255)));
      drain();
      set_reg(REG_ENABLE, 8'd1);

      // default header and trailer with 00/FF body, then one junk byte to force a slip
      send_frame(1'b1, -1);
      send_byte(8'hC3);
      stream_bytes(PHASE_BYTES);

      // all-zero/all-one register values, no idling on either side
      drain();
      program_headers(8'h00, 8'hFF, 8'h00);
      send_idle_pct <= 0;
      stall_pct <= 0;
      stream_bytes(PHASE_BYTES);

      // opposite extremes, long receiver hold-off while bytes keep coming
      drain();
      program_headers(8'hFF, 8'h00, 8'hFF);
      send_idle_pct <= 30;
      stall_pct <= 30;
      hold_seq <= hold_seq + 1;
      stream_bytes(PHASE_BYTES);

      // disable with bit 0 clear in a nonzero write; ring and pointers kept
      drain();
      set_reg(REG_ENABLE, 8'd2);
      repeat (10) send_byte(BYTE_W'($urandom_range(255)));
      drain();
      set_reg(REG_ENABLE, 8'd1);
      program_headers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                      BYTE_W'($urandom_range(255)));
      stream_bytes(PHASE_BYTES);

      drain();
      program_headers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                      BYTE_W'($urandom_range(255)));
      stream_bytes(PHASE_BYTES);

      drain();
      if (mismatch_count == 0 && frame_bytes_owed == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
